[sv/hbom_pkg.sv]
// ----------------------------------------------------------------------------
// hbom_pkg: shared types and constants of the helmet box overlap matcher
// box layouts, operation codes, counter limits and match stage results
// ----------------------------------------------------------------------------
package hbom_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned EDGE_W  = COORD_W + 1;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned BOX_W   = 4 * COORD_W;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(200);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // left in the lowest bits
  typedef struct packed {
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  // upper half of the person box as edges
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [EDGE_W-1:0]  right;
    logic [COORD_W-1:0] top;
    logic [EDGE_W-1:0]  bottom;
  } person_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } hit_t;

endpackage

[sv/hbom_ram.sv]
// ----------------------------------------------------------------------------
// hbom_ram: generic single write port ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hbom_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/hbom_match.sv]
// ----------------------------------------------------------------------------
// hbom_match: shared overlap test unit
// four stage pipeline, one stored hat per cycle against the person half box
// ----------------------------------------------------------------------------
module hbom_match (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          last_i,
  input  hbom_pkg::box_t                hat_i,
  input  hbom_pkg::person_t             person_i,
  input  logic [hbom_pkg::THR_W-1:0]    thr_i,
  output hbom_pkg::hit_t                hit_o
);

  localparam int unsigned EW  = hbom_pkg::EDGE_W;
  localparam int unsigned CW  = hbom_pkg::COORD_W;
  localparam int unsigned OVW = 2 * EW;
  localparam int unsigned HAW = 2 * CW;
  localparam int unsigned LW  = OVW + 10;
  localparam int unsigned RW  = HAW + hbom_pkg::THR_W;

  logic [EW-1:0]  hat_r, hat_b;
  logic [CW-1:0]  xl, yt;
  logic [EW-1:0]  xr, yb;
  logic [EW-1:0]  ow_d, oh_d;

  logic [1:0]     v_q [3:0];
  logic [EW-1:0]  ow_q, oh_q;
  logic [CW-1:0]  hw_q, hh_q;
  logic [OVW-1:0] ov_q;
  logic [HAW-1:0] ha_q;
  logic [LW-1:0]  lhs_q;
  logic [RW-1:0]  rhs_q;
  logic           nz_q;
  logic           hit_q;

  // overlap extents
  always_comb begin
    hat_r = {1'b0, hat_i.left} + {1'b0, hat_i.width};
    hat_b = {1'b0, hat_i.top} + {1'b0, hat_i.height};
    xl    = (person_i.left > hat_i.left) ? person_i.left : hat_i.left;
    yt    = (person_i.top > hat_i.top) ? person_i.top : hat_i.top;
    xr    = (person_i.right < hat_r) ? person_i.right : hat_r;
    yb    = (person_i.bottom < hat_b) ? person_i.bottom : hat_b;
    ow_d  = (xr > {1'b0, xl}) ? (xr - {1'b0, xl}) : '0;
    oh_d  = (yb > {1'b0, yt}) ? (yb - {1'b0, yt}) : '0;
  end

  // stage valid and last tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        v_q[i] <= 2'b00;
      end
    end else begin
      v_q[0] <= {last_i, valid_i};
      for (int i = 1; i < 4; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ow_q  <= ow_d;
    oh_q  <= oh_d;
    hw_q  <= hat_i.width;
    hh_q  <= hat_i.height;
    ov_q  <= OVW'(ow_q) * OVW'(oh_q);
    ha_q  <= HAW'(hw_q) * HAW'(hh_q);
    // times 1000 as 1024 - 16 - 8
    lhs_q <= {ov_q, 10'b0} - LW'({ov_q, 4'b0}) - LW'({ov_q, 3'b0});
    rhs_q <= RW'(thr_i) * RW'(ha_q);
    nz_q  <= (ha_q != '0);
    hit_q <= nz_q && (lhs_q > LW'(rhs_q));
  end

  assign hit_o.valid = v_q[3][0];
  assign hit_o.last  = v_q[3][1];
  assign hit_o.hit   = hit_q;

endmodule

[sv/helmet_box_overlap_matcher.sv]
// ----------------------------------------------------------------------------
// helmet_box_overlap_matcher: hat store and person helmet check
// clear and store words are taken while idle; a check holds ready low until
// its output word is registered, streaming one stored hat per
// cycle through the ram read port into the shared overlap unit, then the ram
// read and compare stages drain; the output word is registered as it ends,
// one word at a time; a check also waits while the previous output word stalls
// reset empties the store, zeroes both counters and sets the threshold to 200
// ----------------------------------------------------------------------------
module helmet_box_overlap_matcher #(
  parameter int unsigned MAX_HATS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hbom_pkg::THR_W-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // left, top, width, height
  input  logic [47:0]                 s_axis_tdata_i,
  // operation
  input  logic [1:0]                  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // helmet_found, persons_seen, persons_without, zero fill
  output logic [23:0]                 m_axis_tdata_o
);

  localparam int unsigned AW   = (MAX_HATS > 1) ? $clog2(MAX_HATS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_HATS + 1);
  localparam int unsigned NW   = hbom_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [CNTW-1:0]            count_q, count_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic [NW-1:0]              seen_q, seen_d;
  logic [NW-1:0]              without_q, without_d;
  logic [hbom_pkg::THR_W-1:0] thr_q;
  logic                       found_q, found_d;
  hbom_pkg::person_t          person_q, person_d;
  logic                       rd_v_q, rd_last_q;
  logic                       out_v_q, out_v_d;
  logic                       out_found_q, out_found_d;
  logic [NW-1:0]              out_seen_q, out_seen_d;
  logic [NW-1:0]              out_without_q, out_without_d;

  hbom_pkg::box_t             in_box;
  hbom_pkg::box_t             hat_rd;
  logic [47:0]                ram_rdata;
  logic                       accept;
  logic                       ram_we;
  logic                       issue;
  logic                       issue_last;
  logic                       out_free;
  hbom_pkg::hit_t             hit;

  assign in_box     = hbom_pkg::box_t'(s_axis_tdata_i);
  assign hat_rd     = hbom_pkg::box_t'(ram_rdata);
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign issue      = (state_q == ST_ISSUE);
  assign issue_last = ((CNTW'(idx_q) + CNTW'(1)) == count_q);
  assign out_free   = !out_v_q || m_axis_tready_i;
  assign ram_we     = accept && (s_axis_tuser_i == hbom_pkg::OP_STORE)
                      && (count_q < CNTW'(MAX_HATS));

  hbom_ram #(
    .WIDTH (hbom_pkg::BOX_W),
    .DEPTH (MAX_HATS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  hbom_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_v_q),
    .last_i   (rd_last_q),
    .hat_i    (hat_rd),
    .person_i (person_q),
    .thr_i    (thr_q),
    .hit_o    (hit)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    seen_d        = seen_q;
    without_d     = without_q;
    found_d       = found_q;
    person_d      = person_q;
    out_v_d       = out_v_q && !m_axis_tready_i;
    out_found_d   = out_found_q;
    out_seen_d    = out_seen_q;
    out_without_d = out_without_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser_i)
            hbom_pkg::OP_CLEAR: begin
              count_d   = '0;
              seen_d    = '0;
              without_d = '0;
            end
            hbom_pkg::OP_STORE: begin
              if (ram_we) begin
                count_d = count_q + CNTW'(1);
              end
            end
            hbom_pkg::OP_CHECK: begin
              person_d.left   = in_box.left;
              person_d.right  = {1'b0, in_box.left} + {1'b0, in_box.width};
              person_d.top    = in_box.top;
              person_d.bottom = {1'b0, in_box.top}
                                + {2'b0, in_box.height[hbom_pkg::COORD_W-1:1]};
              found_d = 1'b0;
              idx_d   = '0;
              state_d = (count_q == '0) ? ST_DONE : ST_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (hit.valid && hit.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          seen_d = (seen_q == hbom_pkg::CNT_MAX) ? seen_q : seen_q + NW'(1);
          if (!found_q && (without_q != hbom_pkg::CNT_MAX)) begin
            without_d = without_q + NW'(1);
          end
          out_v_d       = 1'b1;
          out_found_d   = found_q;
          out_seen_d    = seen_d;
          out_without_d = without_d;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (hit.valid && hit.hit) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      seen_q    <= '0;
      without_q <= '0;
      found_q   <= 1'b0;
      thr_q     <= hbom_pkg::THR_RESET;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      seen_q    <= seen_d;
      without_q <= without_d;
      found_q   <= found_d;
      rd_v_q    <= issue;
      rd_last_q <= issue && issue_last;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    person_q      <= person_d;
    out_found_q   <= out_found_d;
    out_seen_q    <= out_seen_d;
    out_without_q <= out_without_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b000, out_without_q, out_seen_q, out_found_q};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_HATS))
    else $error("hat count beyond store depth");

  a_without_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    without_q <= seen_q)
    else $error("persons without exceeds persons seen");

  a_idx_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (CNTW'(idx_q) < count_q))
    else $error("read beyond stored hats");

  a_hit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit.valid |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("match result outside a check");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && hit.valid && hit.last) |=> (state_q == ST_DONE))
    else $error("check did not finish after last hat");

endmodule
